@@ rtl/bpu_pkg.sv @@
// ---------------------------------------------------------------------------
// bpu_pkg
// Shared types, codes and constant tables of the byte pointer unit.
// ---------------------------------------------------------------------------
package bpu_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        KIND_INC = 2'd0,
        KIND_ADJ = 2'd1,
        KIND_LDB = 2'd2,
        KIND_DPB = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_TWG   = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    localparam logic [5:0] WORD_BITS = 6'd36;
    localparam logic [5:0] OWG_FIRST = 6'd37;
    localparam int         OWG_COUNT = 27;

    // One-word global pointer table entry
    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] size;
        logic [5:0] next;
        logic       carry;
    } owg_entry_t;

    // Quotient and remainder of a small division
    typedef struct packed {
        logic [5:0] q;
        logic [5:0] r;
    } div6_t;

    // Search result of the table re-encode
    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } owg_find_t;

    // Word travelling down the pipeline
    typedef struct packed {
        logic              adj;
        logic              owg;
        logic [35:0]       bp;
        logic [35:0]       newbp;
        logic [35:0]       data;
        status_t           status;
        logic [31:0]       count;
        logic [5:0]        pos;
        logic [5:0]        size;
        logic [5:0]        align;
        logic [5:0]        bpw;
        logic signed [7:0] cur;
        logic              neg;
        logic [30:0]       x;
        logic [31:0]       recip;
        logic [30:0]       q0;
        logic [31:0]       q;
        logic [5:0]        r;
    } bpu_item_t;

    // Global pointer table, indexed by P - 37
    function automatic owg_entry_t owg_lookup(input logic [4:0] idx);
        owg_entry_t e;
        case (idx)
            5'd0:  e = '{6'd36, 6'd6,  6'd38, 1'b0};
            5'd1:  e = '{6'd30, 6'd6,  6'd39, 1'b0};
            5'd2:  e = '{6'd24, 6'd6,  6'd40, 1'b0};
            5'd3:  e = '{6'd18, 6'd6,  6'd41, 1'b0};
            5'd4:  e = '{6'd12, 6'd6,  6'd42, 1'b0};
            5'd5:  e = '{6'd6,  6'd6,  6'd43, 1'b0};
            5'd6:  e = '{6'd0,  6'd6,  6'd38, 1'b1};
            5'd7:  e = '{6'd36, 6'd8,  6'd45, 1'b0};
            5'd8:  e = '{6'd28, 6'd8,  6'd46, 1'b0};
            5'd9:  e = '{6'd20, 6'd8,  6'd47, 1'b0};
            5'd10: e = '{6'd12, 6'd8,  6'd48, 1'b0};
            5'd11: e = '{6'd4,  6'd8,  6'd45, 1'b1};
            5'd12: e = '{6'd36, 6'd7,  6'd50, 1'b0};
            5'd13: e = '{6'd29, 6'd7,  6'd51, 1'b0};
            5'd14: e = '{6'd22, 6'd7,  6'd52, 1'b0};
            5'd15: e = '{6'd15, 6'd7,  6'd53, 1'b0};
            5'd16: e = '{6'd8,  6'd7,  6'd54, 1'b0};
            5'd17: e = '{6'd1,  6'd7,  6'd50, 1'b1};
            5'd18: e = '{6'd36, 6'd9,  6'd56, 1'b0};
            5'd19: e = '{6'd27, 6'd9,  6'd57, 1'b0};
            5'd20: e = '{6'd18, 6'd9,  6'd58, 1'b0};
            5'd21: e = '{6'd9,  6'd9,  6'd59, 1'b0};
            5'd22: e = '{6'd0,  6'd9,  6'd56, 1'b1};
            5'd23: e = '{6'd36, 6'd18, 6'd61, 1'b0};
            5'd24: e = '{6'd18, 6'd18, 6'd62, 1'b0};
            5'd25: e = '{6'd0,  6'd18, 6'd61, 1'b1};
            5'd26: e = '{6'd0,  6'd36, 6'd63, 1'b1};
            default: e = '0;
        endcase
        return e;
    endfunction

    // First table entry with the given position and size
    function automatic owg_find_t owg_find(input logic [5:0] size, input logic [5:0] pos);
        owg_find_t  f;
        owg_entry_t e;
        f = '0;
        for (int i = OWG_COUNT - 1; i >= 0; i--) begin
            e = owg_lookup(5'(i));
            if (e.size == size && e.pos == pos) begin
                f.found = 1'b1;
                f.idx   = 5'(i);
            end
        end
        return f;
    endfunction

    // Restoring division of two 6-bit values, one bit a step
    function automatic div6_t udiv6(input logic [5:0] a, input logic [5:0] b);
        div6_t      d;
        logic [6:0] rem;
        d   = '0;
        rem = '0;
        for (int i = 5; i >= 0; i--) begin
            rem = {rem[5:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                d.q[i] = 1'b1;
            end
        end
        d.r = rem[5:0];
        return d;
    endfunction

    // floor(2^32 / b), all ones for b = 1; used to divide by bytes per word
    function automatic logic [31:0] recip32(input logic [5:0] b);
        logic [31:0] v;
        case (b)
            6'd1:  v = 32'hFFFF_FFFF;
            6'd2:  v = 32'd2147483648;
            6'd3:  v = 32'd1431655765;
            6'd4:  v = 32'd1073741824;
            6'd5:  v = 32'd858993459;
            6'd6:  v = 32'd715827882;
            6'd7:  v = 32'd613566756;
            6'd8:  v = 32'd536870912;
            6'd9:  v = 32'd477218588;
            6'd10: v = 32'd429496729;
            6'd11: v = 32'd390451572;
            6'd12: v = 32'd357913941;
            6'd13: v = 32'd330382099;
            6'd14: v = 32'd306783378;
            6'd15: v = 32'd286331153;
            6'd16: v = 32'd268435456;
            6'd17: v = 32'd252645135;
            6'd18: v = 32'd238609294;
            6'd19: v = 32'd226050910;
            6'd20: v = 32'd214748364;
            6'd21: v = 32'd204522252;
            6'd22: v = 32'd195225786;
            6'd23: v = 32'd186737708;
            6'd24: v = 32'd178956970;
            6'd25: v = 32'd171798691;
            6'd26: v = 32'd165191049;
            6'd27: v = 32'd159072862;
            6'd28: v = 32'd153391689;
            6'd29: v = 32'd148102320;
            6'd30: v = 32'd143165576;
            6'd31: v = 32'd138547332;
            6'd32: v = 32'd134217728;
            6'd33: v = 32'd130150524;
            6'd34: v = 32'd126322567;
            6'd35: v = 32'd122713351;
            6'd36: v = 32'd119304647;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/bpu_front.sv @@
// ---------------------------------------------------------------------------
// bpu_front
// Decode, increment, load/deposit, then byte geometry for adjust.
// ---------------------------------------------------------------------------
module bpu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              ext,
    input  logic              in_valid,
    input  logic [1:0]        kind,
    input  logic [35:0]       pointer_word,
    input  logic [35:0]       operand_word,
    input  logic [35:0]       memory_word,
    output logic              out_valid,
    output bpu_pkg::bpu_item_t out_item
);
    import bpu_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    bpu_item_t  s1_reg, s1_next;
    logic       s2_valid_reg, s2_valid_next;
    bpu_item_t  s2_reg, s2_next;

    // Stage 1: decode, increment, load and deposit
    always_comb
    begin
        logic [5:0]  p, s, pos, size, np;
        logic [5:0]  pidx;
        logic        owg, twg;
        owg_entry_t  e;
        div6_t       da;
        logic [35:0] m;
        logic [17:0] y;
        logic [6:0]  psum;

        p    = pointer_word[35:30];
        s    = pointer_word[29:24];
        owg  = ext && (p >= OWG_FIRST);
        twg  = ext && !owg && pointer_word[23];
        pidx = p - OWG_FIRST;
        e    = owg_lookup(pidx[4:0]);
        pos  = owg ? e.pos : p;
        size = owg ? e.size : s;
        np   = p - s;
        y    = pointer_word[17:0];
        da   = udiv6(pos, size);

        s1_next        = '0;
        s1_next.bp     = pointer_word;
        s1_next.newbp  = pointer_word;
        s1_next.count  = operand_word[31:0];
        s1_next.owg    = owg;
        s1_next.pos    = pos;
        s1_next.size   = size;
        s1_next.status = STAT_OK;
        s1_next.align  = da.r;

        // Load/deposit field with clamping
        psum = {1'b0, pos} + {1'b0, size};
        if (psum > {1'b0, WORD_BITS}) begin
            if (pos < WORD_BITS)
            begin
                size = WORD_BITS - pos;
            end
            else
            begin
                pos  = '0;
                size = '0;
            end
        end
        m = (size >= WORD_BITS) ? '1 : ((36'd1 << size) - 36'd1);

        if (twg) begin
            s1_next.status = STAT_TWG;
            if (kind == KIND_DPB)
            begin
                s1_next.data = memory_word;
            end
        end
        else
        begin
            case (kind)
                KIND_INC:
                begin
                    if (owg)
                    begin
                        s1_next.newbp = {e.next, 30'(pointer_word[29:0] + 30'(e.carry))};
                    end
                    else
                    begin
                        if (p < s)
                        begin
                            np = WORD_BITS - s;
                            y  = y + 18'd1;
                        end
                        s1_next.newbp = {np, pointer_word[29:18], y};
                    end
                end
                KIND_ADJ:
                begin
                    s1_next.adj = owg || (s != 6'd0);
                end
                KIND_LDB:
                begin
                    s1_next.data = (memory_word >> pos) & m;
                end
                default:
                begin
                    s1_next.data = (memory_word & ~(m << pos)) | ((operand_word & m) << pos);
                end
            endcase
        end
        s1_valid_next = in_valid;
    end

    // Stage 2: bytes per word and current byte index
    always_comb
    begin
        div6_t      db, dc;
        logic [5:0] rem_bits;
        logic [5:0] cdiff;

        s2_next       = s1_reg;
        s2_valid_next = s1_valid_reg;
        rem_bits      = WORD_BITS - s1_reg.align;
        db            = udiv6(rem_bits, s1_reg.size);
        if (s1_reg.pos <= WORD_BITS)
        begin
            cdiff = WORD_BITS - s1_reg.pos;
        end
        else
        begin
            cdiff = s1_reg.pos - WORD_BITS;
        end
        dc = udiv6(cdiff, s1_reg.size);

        s2_next.bpw = (s1_reg.align > WORD_BITS) ? 6'd0 : db.q;
        if (s1_reg.pos <= WORD_BITS)
        begin
            s2_next.cur = 8'(dc.q) - 8'sd1;
        end
        else
        begin
            s2_next.cur = -8'(dc.q) - 8'sd1;
        end
        if (s1_reg.adj && (s2_next.bpw == 6'd0))
        begin
            s2_next.adj    = 1'b0;
            s2_next.status = STAT_RANGE;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

@@ rtl/bpu_div.sv @@
// ---------------------------------------------------------------------------
// bpu_div
// Floor division of the adjusted byte index by bytes per word,
// through a reciprocal multiply and one correction step.
// ---------------------------------------------------------------------------
module bpu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  bpu_pkg::bpu_item_t in_item,
    output logic              out_valid,
    output bpu_pkg::bpu_item_t out_item
);
    import bpu_pkg::*;

    logic      s3_valid_reg, s4_valid_reg, s5_valid_reg;
    bpu_item_t s3_reg, s3_next, s4_reg, s4_next, s5_reg, s5_next;

    // Stage 3: index sum, magnitude for floor division, reciprocal
    always_comb
    begin
        logic [31:0] n;
        n             = in_item.count + {{24{in_item.cur[7]}}, in_item.cur};
        s3_next       = in_item;
        s3_next.neg   = n[31];
        s3_next.x     = n[31] ? ~n[30:0] : n[30:0];
        s3_next.recip = recip32(in_item.bpw);
    end

    // Stage 4: estimate quotient, low by at most one
    always_comb
    begin
        logic [62:0] prod;
        prod       = 63'(s3_reg.x) * 63'(s3_reg.recip);
        s4_next    = s3_reg;
        s4_next.q0 = prod[62:32];
    end

    // Stage 5: correct, then fold back the sign
    always_comb
    begin
        logic [30:0] r0;
        logic [30:0] qm;
        logic [5:0]  rm;
        r0 = s4_reg.x - 31'(s4_reg.q0 * 31'(s4_reg.bpw));
        if (r0 >= 31'(s4_reg.bpw))
        begin
            qm = s4_reg.q0 + 31'd1;
            rm = 6'(r0 - 31'(s4_reg.bpw));
        end
        else
        begin
            qm = s4_reg.q0;
            rm = r0[5:0];
        end
        s5_next = s4_reg;
        if (s4_reg.neg)
        begin
            s5_next.q = ~{1'b0, qm};
            s5_next.r = s4_reg.bpw - 6'd1 - rm;
        end
        else
        begin
            s5_next.q = {1'b0, qm};
            s5_next.r = rm;
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_item  = s5_reg;

endmodule

@@ rtl/bpu_back.sv @@
// ---------------------------------------------------------------------------
// bpu_back
// Rebuilds the adjusted pointer and holds the output word.
// ---------------------------------------------------------------------------
module bpu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  bpu_pkg::bpu_item_t in_item,
    output logic              out_valid,
    output logic [35:0]       new_pointer,
    output logic [35:0]       data_word,
    output logic [1:0]        status
);
    import bpu_pkg::*;

    logic        valid_reg;
    logic [35:0] ptr_reg, ptr_next;
    logic [35:0] data_reg;
    logic [1:0]  stat_reg, stat_next;

    // New position and pointer re-encode
    always_comb
    begin
        logic [11:0] t;
        logic [5:0]  span;
        owg_find_t   f;

        span      = in_item.bpw - 6'd1 - in_item.r;
        t         = 12'(span) * 12'(in_item.size) + 12'(in_item.align);
        f         = owg_find(in_item.size, t[5:0]);
        ptr_next  = in_item.newbp;
        stat_next = in_item.status;
        if (in_item.adj)
        begin
            if (in_item.owg)
            begin
                if (f.found)
                begin
                    ptr_next = {6'(f.idx) + OWG_FIRST,
                                30'(in_item.bp[29:0] + in_item.q[29:0])};
                end
                else
                begin
                    stat_next = STAT_RANGE;
                end
            end
            else
            begin
                ptr_next = {t[5:0], in_item.bp[29:18],
                            18'(in_item.bp[17:0] + in_item.q[17:0])};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ptr_reg  <= ptr_next;
            data_reg <= in_item.data;
            stat_reg <= stat_next;
        end
    end

    assign out_valid   = valid_reg;
    assign new_pointer = ptr_reg;
    assign data_word   = data_reg;
    assign status      = stat_reg;

endmodule

@@ rtl/byte_pointer_unit.sv @@
// ---------------------------------------------------------------------------
// byte_pointer_unit
// Increment, adjust, load byte and deposit byte on one pointer word.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake             Word
//  input     in         in_valid / in_ready   kind, pointer_word, operand_word,
//                                             memory_word
//  output    out        out_valid / out_ready new_pointer, data_word, status
//  config    in         APB psel / penable    extended_section at 0x0
//
//  Six register stages: front s1 and s2, divide s3 to s5, and the output
//  register. One word per cycle while the output is not stalled; the adjust divide
//  (reciprocal multiply and correction) sets the depth.
//  Reset clears all stage valid bits and extended_section.
//  A stall at the output freezes every stage together; in_ready falls with it.
// ---------------------------------------------------------------------------
module byte_pointer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [35:0] pointer_word,
    input  logic [35:0] operand_word,
    input  logic [35:0] memory_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [35:0] new_pointer,
    output logic [35:0] data_word,
    output logic [1:0]  status
);
    import bpu_pkg::*;

    logic      ext_reg;
    logic      en;
    logic      fr_valid, dv_valid;
    bpu_item_t fr_item, dv_item;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            ext_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, ext_reg};

    // Whole pipeline advances unless the output word is held
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    bpu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .ext          (ext_reg),
        .in_valid     (in_valid),
        .kind         (kind),
        .pointer_word (pointer_word),
        .operand_word (operand_word),
        .memory_word  (memory_word),
        .out_valid    (fr_valid),
        .out_item     (fr_item)
    );

    bpu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    bpu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (dv_valid),
        .in_item     (dv_item),
        .out_valid   (out_valid),
        .new_pointer (new_pointer),
        .data_word   (data_word),
        .status      (status)
    );

endmodule

@@ rtl/bpu_checker.sv @@
// ---------------------------------------------------------------------------
// bpu_checker
// Port-level checks of the byte pointer unit, bound to the top level.
// ---------------------------------------------------------------------------
module bpu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [35:0] new_pointer,
    input logic [35:0] data_word,
    input logic [1:0]  status
);
    import bpu_pkg::*;

    // Held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(new_pointer)
            && $stable(data_word) && $stable(status))
        else $error("output word changed while stalled");

    // Input side is never blocked when the output drains
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output is taken");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_TWG
            || status == STAT_RANGE))
        else $error("undefined status code");

    // A stall at the output blocks the input
    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted during output stall");

endmodule

bind byte_pointer_unit bpu_checker u_bpu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .new_pointer (new_pointer),
    .data_word   (data_word),
    .status      (status)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the byte pointer unit: directed and random increment, adjust, load
// and deposit words in both section modes, against a cycle-free predictor,
// with random idling on the input and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bpu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [35:0] ptr;
        logic [35:0] data;
        status_t     st;
    } bp_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [35:0] pointer_word;
    logic [35:0] operand_word;
    logic [35:0] memory_word;
    logic        out_valid;
    logic        out_ready;
    logic [35:0] new_pointer;
    logic [35:0] data_word;
    logic [1:0]  status;

    bp_result_t expected_words [$];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         idle_on = 0;
    bit         ext_mode = 0;
    int         stall_left = 0;

    // One-word global pointer table: position, size, next P, address carry
    int gt_pos   [0:26] = '{36, 30, 24, 18, 12, 6, 0, 36, 28, 20, 12, 4,
                            36, 29, 22, 15, 8, 1, 36, 27, 18, 9, 0, 36, 18, 0, 0};
    int gt_size  [0:26] = '{6, 6, 6, 6, 6, 6, 6, 8, 8, 8, 8, 8, 7, 7, 7, 7, 7, 7,
                            9, 9, 9, 9, 9, 18, 18, 18, 36};
    int gt_next  [0:26] = '{38, 39, 40, 41, 42, 43, 38, 45, 46, 47, 48, 45,
                            50, 51, 52, 53, 54, 50, 56, 57, 58, 59, 56, 61, 62, 61, 63};
    int gt_carry [0:26] = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1,
                            0, 0, 0, 0, 1, 0, 0, 1, 1};

    byte_pointer_unit dut (.*);

    // Clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Move a pointer by a byte count; returns 0 when no whole byte fits a word
    function automatic bit adjust_calc(input int pos, input int size,
                                       input logic [31:0] count,
                                       input logic [29:0] addr,
                                       input logic [29:0] amask,
                                       output int npos, output logic [29:0] naddr);
        int     align;
        int     bpw;
        int     cur;
        int     n;
        longint q;
        longint r;
        npos = 0;
        naddr = addr;
        align = pos % size;
        bpw = (36 - align) / size;
        if (bpw <= 0)
            return 0;
        cur = (36 - pos) / size - 1;
        n = count + cur;
        q = n / bpw;
        r = n % bpw;
        if (r < 0)
        begin
            r = r + bpw;
            q = q - 1;
        end
        npos = int'((bpw - 1 - r) * size + align);
        naddr = (addr + 30'(q)) & amask;
        return 1;
    endfunction

    // Expected result of one word
    function automatic bp_result_t predict_word(input kind_t k, input logic [35:0] bp,
                                                input logic [35:0] opnd,
                                                input logic [35:0] mem, input bit ext);
        bp_result_t  res;
        int          p;
        int          s;
        int          np;
        int          pos;
        int          size;
        int          found;
        bit          owg;
        bit          twg;
        logic [29:0] na;
        logic [17:0] y;
        logic [63:0] m;
        p = int'(bp[35:30]);
        s = int'(bp[29:24]);
        owg = ext && p >= 37;
        twg = ext && !owg && bp[23];
        res.ptr = bp;
        res.data = '0;
        res.st = STAT_OK;
        pos = p;
        size = s;
        if (twg)
        begin
            res.st = STAT_TWG;
            if (k == KIND_DPB)
                res.data = mem;
        end
        else if (k == KIND_INC)
        begin
            if (owg)
                res.ptr = {6'(gt_next[p - 37]), bp[29:0] + 30'(gt_carry[p - 37])};
            else
            begin
                np = p - s;
                y = bp[17:0];
                if (np < 0)
                begin
                    np = (36 - s) & 63;
                    y = y + 18'd1;
                end
                res.ptr = {6'(np), bp[29:18], y};
            end
        end
        else if (k == KIND_ADJ)
        begin
            if (owg)
            begin
                if (!adjust_calc(gt_pos[p - 37], gt_size[p - 37], opnd[31:0], bp[29:0],
                                 30'h3FFF_FFFF, np, na))
                    res.st = STAT_RANGE;
                else
                begin
                    found = -1;
                    for (int i = 0; i < 27; i++)
                        if (found < 0 && gt_size[i] == gt_size[p - 37] && gt_pos[i] == np)
                            found = i;
                    if (found < 0)
                        res.st = STAT_RANGE;
                    else
                        res.ptr = {6'(found + 37), na};
                end
            end
            else if (s != 0)
            begin
                if (!adjust_calc(p, s, opnd[31:0], {12'd0, bp[17:0]}, 30'h3FFFF, np, na))
                    res.st = STAT_RANGE;
                else
                    res.ptr = {6'(np & 63), bp[29:18], na[17:0]};
            end
        end
        else
        begin
            if (owg)
            begin
                pos = gt_pos[p - 37];
                size = gt_size[p - 37];
            end
            if (pos + size > 36)
            begin
                if (pos < 36)
                    size = 36 - pos;
                else
                begin
                    pos = 0;
                    size = 0;
                end
            end
            m = (size <= 0) ? 64'd0 : ((64'd1 << size) - 64'd1);
            if (k == KIND_LDB)
                res.data = 36'(({28'd0, mem} >> pos) & m);
            else
                res.data = 36'(({28'd0, mem} & ~(m << pos)) | (({28'd0, opnd} & m) << pos));
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [35:0] got,
                                   input logic [35:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Send one word; returns at the accepting edge
    task automatic send_word(input kind_t k, input logic [35:0] bp, input logic [35:0] opnd,
                             input logic [35:0] mem);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        kind <= k;
        pointer_word <= bp;
        operand_word <= opnd;
        memory_word <= mem;
        do
            @(posedge clk);
        while (!in_ready);
        expected_words.push_back(predict_word(k, bp, opnd, mem, ext_mode));
    endtask

    // Wait for every word to drain, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_section(input bit value);
        wait_idle();
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= '0;
        pwdata <= {31'd0, value};
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        ext_mode = value;
    endtask

    function automatic logic [35:0] rand36();
        return {4'($urandom), 32'($urandom)};
    endfunction

    // Pointers mostly well formed, with some wholly random ones
    function automatic logic [35:0] rand_pointer();
        logic [35:0] bp;
        int          sel;
        bp = rand36();
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            bp[35:30] = 6'($urandom_range(0, 36));
            bp[29:24] = 6'($urandom_range(1, 36));
            bp[23] = ($urandom_range(0, 5) == 0);
        end
        else if (sel < 7)
        begin
            bp[35:30] = 6'($urandom_range(37, 63));
            if ($urandom_range(0, 3) == 0)
                bp[29:0] = 30'h3FFF_FFFF - 30'($urandom_range(0, 3));
        end
        else if (sel == 7)
            bp[17:0] = 18'h3FFFF;
        return bp;
    endfunction

    function automatic logic [35:0] rand_count();
        logic [35:0] c;
        c = rand36();
        case ($urandom_range(0, 3))
            0: c[31:0] = 32'($urandom_range(0, 40)) - 32'd20;
            1: c[31:0] = 32'($urandom_range(0, 400)) - 32'd200;
            default: ;
        endcase
        return c;
    endfunction

    task automatic test_local_directed();
        send_word(KIND_INC, {6'd0, 6'd6, 6'd0, 18'h00010}, '0, '0);
        send_word(KIND_INC, {6'd3, 6'd7, 6'h3F, 18'h3FFFF}, '0, '0);
        send_word(KIND_INC, {6'd36, 6'd0, 6'd0, 18'h00000}, '0, '0);
        send_word(KIND_INC, {6'd63, 6'd63, 6'h3F, 18'h3FFFF}, '1, '1);
        send_word(KIND_ADJ, {6'd30, 6'd0, 6'd0, 18'h00100}, 36'd5, '0);
        send_word(KIND_ADJ, {6'd0, 6'd37, 6'd0, 18'h00100}, 36'd1, '0);
        send_word(KIND_ADJ, {6'd36, 6'd7, 6'd0, 18'h00000}, 36'hF_FFFF_FFFF, '0);
        send_word(KIND_ADJ, {6'd1, 6'd7, 6'd0, 18'h3FFFF}, 36'h0_7FFF_FFFF, '0);
        send_word(KIND_ADJ, {6'd12, 6'd6, 6'd0, 18'h00010}, 36'h0_8000_0000, '0);
        send_word(KIND_LDB, {6'd30, 6'd12, 6'd0, 18'd0}, '0, 36'hF_0123_4567);
        send_word(KIND_LDB, {6'd40, 6'd6, 6'd0, 18'd0}, '0, '1);
        send_word(KIND_LDB, {6'd0, 6'd36, 6'd0, 18'd0}, '0, 36'hA_5A5A_5A5A);
        send_word(KIND_DPB, {6'd0, 6'd36, 6'd0, 18'd0}, '1, '0);
        send_word(KIND_DPB, {6'd8, 6'd4, 6'd0, 18'd0}, '1, '0);
        send_word(KIND_DPB, {6'd50, 6'd9, 6'd0, 18'd0}, '1, 36'h1_2345_6789);
        send_word(KIND_LDB, {6'd2, 6'd40, 6'h20, 18'd0}, '0, '1);
    endtask

    task automatic test_global_directed();
        send_word(KIND_INC, {6'd43, 30'h0000_0010}, '0, '0);
        send_word(KIND_INC, {6'd63, 30'h3FFF_FFFF}, '0, '0);
        send_word(KIND_ADJ, {6'd37, 30'h0000_0100}, 36'd13, '0);
        send_word(KIND_ADJ, {6'd55, 30'h0000_0000}, 36'hF_FFFF_FFF0, '0);
        send_word(KIND_ADJ, {6'd62, 30'h3FFF_FFFF}, 36'h0_7FFF_FFFF, '0);
        send_word(KIND_LDB, {6'd46, 30'd0}, '0, 36'hF_EDCB_A987);
        send_word(KIND_DPB, {6'd54, 30'd0}, '1, '0);
        send_word(KIND_INC, {6'd10, 6'd6, 1'b1, 5'd0, 18'h00001}, '0, '0);
        send_word(KIND_ADJ, {6'd10, 6'd6, 1'b1, 5'd0, 18'h00001}, 36'd3, '0);
        send_word(KIND_DPB, {6'd10, 6'd6, 1'b1, 5'd0, 18'h00001}, '1, 36'h5_5555_5555);
    endtask

    task automatic test_random(input int count);
        kind_t k;
        for (int i = 0; i < count; i++)
        begin
            k = kind_t'($urandom_range(0, 3));
            send_word(k, rand_pointer(), (k == KIND_ADJ) ? rand_count() : rand36(),
                      rand36());
        end
    endtask

    // Output stalls
    initial
    begin
        out_ready = 1;
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 12);
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Result check
    always @(posedge clk)
    begin
        bp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("unexpected word at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (new_pointer !== want.ptr)
                    report_mismatch("new_pointer", new_pointer, want.ptr);
                if (data_word !== want.data)
                    report_mismatch("data_word", data_word, want.data);
                if (status !== want.st)
                    report_mismatch("status", {34'd0, status}, {34'd0, want.st});
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        kind = '0;
        pointer_word = '0;
        operand_word = '0;
        memory_word = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        test_local_directed();
        write_section(1);
        test_global_directed();
        test_local_directed();
        idle_on = 1;
        test_random(200);
        write_section(0);
        test_random(200);
        write_section(1);
        test_random(200);
        idle_on = 0;
        write_section(0);
        test_random(75);
        write_section(1);
        test_random(75);

        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
